// ----- rtl/core/cfsr_pkg.sv -----
`default_nettype none

package cfsr_pkg;

   localparam logic [7:0]  HEADER_BYTE           = 8'hA5;
   localparam int          DEFAULT_COMMAND_WORDS = 4;
   localparam int          INPUT_WORDS           = 4;
   localparam int          JOB_QUEUE_DEPTH       = 2;
   localparam logic [15:0] RESEND_TICKS_RESET    = 16'd10;
   localparam logic [15:0] MAX_WAIT_TICKS_RESET  = 16'd100;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_RELIABLE   = 2'd1,
      OP_UNRELIABLE = 2'd2,
      OP_RX         = 2'd3
   } cfsr_op_type;

   typedef enum logic [1:0] {
      STATUS_ACKED     = 2'd0,
      STATUS_TIMED_OUT = 2'd1,
      STATUS_BUSY      = 2'd2
   } cfsr_status_type;

   typedef enum logic {
      CSR_RESEND_TICKS   = 1'b0,
      CSR_MAX_WAIT_TICKS = 1'b1
   } cfsr_csr_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FRAME = 2'd1,
      BK_ACK   = 2'd2
   } cfsr_back_state_type;

   // One job handed from the front to the back; command words travel beside it.
   typedef struct packed {
      logic            is_frame;
      logic            ack_follows;
      cfsr_status_type status;
      logic [7:0]      seq;
      logic [7:0]      id;
   } cfsr_job_hdr_type;

   // Queue status seen by producer and consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } cfsr_queue_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/command_frame_sender_with_retry.sv -----
// Command frame sender with acknowledged retry. Every accepted item is classified at once by
// the front end, which owns the sequence number, the wait counters and the held frame, and
// turns it into at most one job (a frame, a frame plus an acked report, or a status report)
// for a two-entry job queue; items that cause no result take no queue slot but are accepted
// only while the queue has room. req_full follows that queue alone, so items go in one per
// cycle until two jobs are pending. The back end serializes jobs into a one-entry output
// register: a frame is loaded, then sent one byte per cycle while the consumer keeps popping
// (4 + 4*COMMAND_WORDS + 1 bytes, 21 at the default) and followed by an acked report if one
// is due; a lone status report goes in once it is free. The checksum is accumulated as the
// bytes leave. Configuration writes take effect on the next tick and are meant for idle time.
`default_nettype none

module command_frame_sender_with_retry
   import cfsr_pkg::*;
#(
   parameter int COMMAND_WORDS = DEFAULT_COMMAND_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [31:0] req_word_zero,
   input  wire logic [31:0] req_word_one,
   input  wire logic [31:0] req_word_two,
   input  wire logic [31:0] req_word_three,
   input  wire logic [7:0]  req_rx_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_kind,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_of_run,
   output logic [1:0]       rsp_status
);

   localparam int WORDS_W = 32 * COMMAND_WORDS;
   localparam int HDR_W   = $bits(cfsr_job_hdr_type);
   localparam int JOB_W   = HDR_W + WORDS_W;

   logic                  job_push, job_pop;
   cfsr_job_hdr_type      push_hdr, head_hdr;
   logic [WORDS_W-1:0]    push_words, head_words;
   logic [JOB_W-1:0]      head_data;
   cfsr_queue_status_type q_status;

   assign req_full = q_status.full;

   cfsr_front #(
      .COMMAND_WORDS(COMMAND_WORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_op         (req_op),
      .req_device_id  (req_device_id),
      .req_word_zero  (req_word_zero),
      .req_word_one   (req_word_one),
      .req_word_two   (req_word_two),
      .req_word_three (req_word_three),
      .req_rx_value   (req_rx_value),
      .job_full       (q_status.full),
      .job_push       (job_push),
      .job_hdr        (push_hdr),
      .job_words      (push_words)
   );

   cfsr_queue #(
      .WIDTH(JOB_W),
      .DEPTH(JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_hdr, push_words}),
      .pop       (job_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   assign head_hdr   = cfsr_job_hdr_type'(head_data[JOB_W-1 -: HDR_W]);
   assign head_words = head_data[WORDS_W-1:0];

   cfsr_back #(
      .COMMAND_WORDS(COMMAND_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (q_status.empty),
      .job_hdr         (head_hdr),
      .job_words       (head_words),
      .job_pop         (job_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status)
   );

   // a frame byte never carries a status code
   a_byte_no_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_kind) |-> (rsp_status == STATUS_ACKED))
      else $error("frame byte with nonzero status");

   // a status report always closes its run and carries no byte
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind) |-> (rsp_last_of_run && rsp_tx_byte == 8'd0))
      else $error("status report malformed");

   // the front never hands a job to a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // a waiting result holds while the consumer stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_tx_byte) && $stable(rsp_kind)))
      else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/core/cfsr_queue.sv -----
`default_nettype none

module cfsr_queue
   import cfsr_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output cfsr_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/cfsr_front.sv -----
`default_nettype none

module cfsr_front
   import cfsr_pkg::*;
#(
   parameter int COMMAND_WORDS = DEFAULT_COMMAND_WORDS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wen,
   input  wire logic                        csr_index,
   input  wire logic [15:0]                 csr_wdata,
   input  wire logic                        req_push,
   input  wire logic [1:0]                  req_op,
   input  wire logic [7:0]                  req_device_id,
   input  wire logic [31:0]                 req_word_zero,
   input  wire logic [31:0]                 req_word_one,
   input  wire logic [31:0]                 req_word_two,
   input  wire logic [31:0]                 req_word_three,
   input  wire logic [7:0]                  req_rx_value,
   input  wire logic                        job_full,
   output logic                             job_push,
   output cfsr_job_hdr_type                 job_hdr,
   output logic [32*COMMAND_WORDS-1:0]      job_words
);

   localparam int WORDS_W = 32 * COMMAND_WORDS;

   logic [15:0]        resend_ticks_ff, max_wait_ticks_ff;
   logic [7:0]         seq_ff, seq_in;
   logic [7:0]         last_rx_ff, last_rx_in;
   logic               waiting_ff, waiting_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [15:0]        since_send_ff, since_send_in;
   logic [7:0]         held_id_ff, held_id_in;
   logic [WORDS_W-1:0] held_words_ff, held_words_in;

   logic [31:0]        in_word [INPUT_WORDS];
   logic [WORDS_W-1:0] loaded_words;
   logic [7:0]         seq_inc;
   logic [15:0]        elapsed_inc, since_send_inc;
   logic               accept, ack_now;
   cfsr_op_type        op;

   assign in_word[0] = req_word_zero;
   assign in_word[1] = req_word_one;
   assign in_word[2] = req_word_two;
   assign in_word[3] = req_word_three;

   always_comb begin
      for (int i = 0; i < COMMAND_WORDS; i++) begin
         loaded_words[32*i +: 32] = (i < INPUT_WORDS) ? in_word[i % INPUT_WORDS] : 32'd0;
      end
   end

   assign op             = cfsr_op_type'(req_op);
   assign accept         = req_push && !job_full;
   assign seq_inc        = seq_ff + 8'd1;
   assign elapsed_inc    = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign since_send_inc = (since_send_ff == 16'hFFFF) ? since_send_ff : since_send_ff + 16'd1;
   assign ack_now        = (last_rx_ff == seq_inc);

   always_comb begin
      seq_in        = seq_ff;
      last_rx_in    = last_rx_ff;
      waiting_in    = waiting_ff;
      elapsed_in    = elapsed_ff;
      since_send_in = since_send_ff;
      held_id_in    = held_id_ff;
      held_words_in = held_words_ff;
      job_push      = 1'b0;
      job_hdr       = '{is_frame: 1'b0, ack_follows: 1'b0, status: STATUS_ACKED,
                        seq: seq_inc, id: held_id_ff};
      job_words     = held_words_ff;
      if (accept) begin
         case (op)
            OP_RELIABLE, OP_UNRELIABLE: begin
               job_push = 1'b1;
               if (waiting_ff) begin
                  job_hdr.status = STATUS_BUSY;
               end else begin
                  seq_in            = seq_inc;
                  held_id_in        = req_device_id;
                  held_words_in     = loaded_words;
                  job_hdr.is_frame  = 1'b1;
                  job_hdr.id        = req_device_id;
                  job_words         = loaded_words;
                  if (op == OP_RELIABLE) begin
                     job_hdr.ack_follows = ack_now;
                     waiting_in          = !ack_now;
                     elapsed_in          = '0;
                     since_send_in       = '0;
                  end
               end
            end
            OP_TICK: begin
               if (waiting_ff) begin
                  elapsed_in    = elapsed_inc;
                  since_send_in = since_send_inc;
                  if (elapsed_inc > max_wait_ticks_ff) begin
                     job_push       = 1'b1;
                     job_hdr.status = STATUS_TIMED_OUT;
                     waiting_in     = 1'b0;
                  end else if (since_send_inc > resend_ticks_ff) begin
                     // resend the held frame under a fresh sequence number
                     job_push            = 1'b1;
                     job_hdr.is_frame    = 1'b1;
                     job_hdr.ack_follows = ack_now;
                     seq_in              = seq_inc;
                     since_send_in       = '0;
                     waiting_in          = !ack_now;
                  end
               end
            end
            OP_RX: begin
               last_rx_in = req_rx_value;
               if (waiting_ff && req_rx_value == seq_ff) begin
                  job_push       = 1'b1;
                  job_hdr.status = STATUS_ACKED;
                  waiting_in     = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resend_ticks_ff   <= RESEND_TICKS_RESET;
         max_wait_ticks_ff <= MAX_WAIT_TICKS_RESET;
         seq_ff            <= '0;
         last_rx_ff        <= '0;
         waiting_ff        <= 1'b0;
         elapsed_ff        <= '0;
         since_send_ff     <= '0;
      end else begin
         if (csr_wen) begin
            case (cfsr_csr_type'(csr_index))
               CSR_RESEND_TICKS:   resend_ticks_ff   <= csr_wdata;
               CSR_MAX_WAIT_TICKS: max_wait_ticks_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         seq_ff        <= seq_in;
         last_rx_ff    <= last_rx_in;
         waiting_ff    <= waiting_in;
         elapsed_ff    <= elapsed_in;
         since_send_ff <= since_send_in;
      end
   end

   always_ff @(posedge clock) begin
      held_id_ff    <= held_id_in;
      held_words_ff <= held_words_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/cfsr_back.sv -----
`default_nettype none

module cfsr_back
   import cfsr_pkg::*;
#(
   parameter int COMMAND_WORDS = DEFAULT_COMMAND_WORDS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_empty,
   input  wire cfsr_job_hdr_type            job_hdr,
   input  wire logic [32*COMMAND_WORDS-1:0] job_words,
   output logic                             job_pop,
   input  wire logic                        rsp_pop,
   output logic                             rsp_empty,
   output logic                             rsp_kind,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_last_of_run,
   output logic [1:0]                       rsp_status
);

   localparam int WORDS_W     = 32 * COMMAND_WORDS;
   localparam int FRAME_BYTES = 4 + 4 * COMMAND_WORDS + 1;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int OFF_W       = $clog2(4 * COMMAND_WORDS);

   cfsr_back_state_type state_ff, state_in;
   cfsr_job_hdr_type    cur_hdr_ff, cur_hdr_in;
   logic [WORDS_W-1:0]  cur_words_ff, cur_words_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [7:0]          sum_ff, sum_in;
   logic [IDX_W-1:0]    word_off;
   logic [7:0]          frame_byte;
   logic                out_free;

   logic                valid_ff, valid_in;
   logic                kind_ff, kind_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   logic [1:0]          status_ff, status_in;

   assign out_free = !valid_ff || rsp_pop;
   assign word_off = idx_ff - IDX_W'(4);

   always_comb begin
      if (idx_ff == IDX_W'(0) || idx_ff == IDX_W'(1)) begin
         frame_byte = HEADER_BYTE;
      end else if (idx_ff == IDX_W'(2)) begin
         frame_byte = cur_hdr_ff.seq;
      end else if (idx_ff == IDX_W'(3)) begin
         frame_byte = cur_hdr_ff.id;
      end else if (idx_ff == IDX_W'(FRAME_BYTES - 1)) begin
         frame_byte = sum_ff;
      end else begin
         frame_byte = cur_words_ff[{word_off[OFF_W-1:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_hdr_in   = cur_hdr_ff;
      cur_words_in = cur_words_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      job_pop      = 1'b0;
      valid_in     = valid_ff && !rsp_pop;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               if (job_hdr.is_frame) begin
                  job_pop      = 1'b1;
                  cur_hdr_in   = job_hdr;
                  cur_words_in = job_words;
                  idx_in       = '0;
                  sum_in       = '0;
                  state_in     = BK_FRAME;
               end else if (out_free) begin
                  job_pop   = 1'b1;
                  valid_in  = 1'b1;
                  kind_in   = 1'b1;
                  byte_in   = '0;
                  last_in   = 1'b1;
                  status_in = job_hdr.status;
               end
            end
         end
         BK_FRAME: begin
            if (out_free) begin
               valid_in  = 1'b1;
               kind_in   = 1'b0;
               byte_in   = frame_byte;
               status_in = STATUS_ACKED;
               last_in   = 1'b0;
               // checksum covers the sequence byte through the last word byte
               if (idx_ff >= IDX_W'(2)) begin
                  sum_in = sum_ff + frame_byte;
               end
               if (idx_ff == IDX_W'(FRAME_BYTES - 1)) begin
                  last_in  = !cur_hdr_ff.ack_follows;
                  state_in = cur_hdr_ff.ack_follows ? BK_ACK : BK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         BK_ACK: begin
            if (out_free) begin
               valid_in  = 1'b1;
               kind_in   = 1'b1;
               byte_in   = '0;
               last_in   = 1'b1;
               status_in = STATUS_ACKED;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_hdr_ff   <= cur_hdr_in;
      cur_words_ff <= cur_words_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_tx_byte     = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire
